// File: rtl/u8clip_pkg.sv
package u8clip_pkg;

	// Field and register widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LIMIT_W  = 16;
	localparam int unsigned LINE_W   = 16;
	localparam int unsigned COLUMN_W = 17;

	// Register index codes on the configuration port
	localparam int unsigned CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_LINES   = 1'b0,
		CFG_MAX_COLUMNS = 1'b1
	} cfg_idx_t;

	// Register reset values
	localparam logic [LIMIT_W-1:0] MAX_LINES_RST   = 16'd200;
	localparam logic [LIMIT_W-1:0] MAX_COLUMNS_RST = 16'd2000;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;

	// Saturation points
	localparam logic [LINE_W-1:0]   LINE_SAT   = '1;
	localparam logic [COLUMN_W-1:0] COLUMN_SAT = '1;

	// Ellipsis run: four bytes, last one flagged
	localparam int unsigned RUN_IDX_W = 2;
	localparam logic [RUN_IDX_W-1:0] RUN_LAST = 2'd3;

	// Decision for one byte, passed from the clipper core to the output stage
	typedef struct packed {
		logic              emit;
		logic              ellipsis;
		logic [BYTE_W-1:0] data;
	} clip_dec_t;

	function automatic logic [BYTE_W-1:0] ellipsis_byte(input logic [RUN_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		b = (idx == '0) ? CH_SPACE : CH_DOT;
		return b;
	endfunction

endpackage

// File: rtl/utf8_text_line_column_clipper.sv
// UTF-8 line and column clipper.
// An accepted byte's result is registered in the output register and shows on the next cycle.
// Throughput: one input byte per cycle while out_ready is high; an ellipsis byte
// becomes a run of four output bytes, with in_ready low until its last byte is taken.
// Reset (arst_n, asynchronous): counters and flags cleared, output empty,
// max_lines = 200, max_columns = 2000.
module utf8_text_line_column_clipper (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [u8clip_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [u8clip_pkg::LIMIT_W-1:0]   cfg_wdata,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [u8clip_pkg::BYTE_W-1:0]    text_byte,
	input  logic                           start_of_text,
	// output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [u8clip_pkg::BYTE_W-1:0]    out_byte,
	output logic                           last_of_run
);
	import u8clip_pkg::*;

	logic [LIMIT_W-1:0]   max_lines_q;
	logic [LIMIT_W-1:0]   max_columns_q;
	logic                 fire;
	logic                 pop;
	clip_dec_t            dec;

	logic                 out_valid_q;
	logic                 ell_q;
	logic [BYTE_W-1:0]    byte_q;
	logic [RUN_IDX_W-1:0] idx_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lines_q   <= MAX_LINES_RST;
			max_columns_q <= MAX_COLUMNS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_LINES:   max_lines_q   <= cfg_wdata;
				CFG_MAX_COLUMNS: max_columns_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshakes: take a new byte once the run in the output register ends
	assign pop      = out_valid_q && out_ready;
	assign in_ready = !out_valid_q || (out_ready && last_of_run);
	assign fire     = in_valid && in_ready;

	u8clip_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.text_byte    (text_byte),
		.start_of_text(start_of_text),
		.max_lines    (max_lines_q),
		.max_columns  (max_columns_q),
		.dec          (dec)
	);

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (pop) begin
				if (last_of_run) begin
					out_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (fire && dec.emit) begin
				out_valid_q <= 1'b1;
				idx_q       <= '0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (fire && dec.emit) begin
			ell_q  <= dec.ellipsis;
			byte_q <= dec.data;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = ell_q ? ellipsis_byte(idx_q) : byte_q;
	assign last_of_run = !ell_q || (idx_q == RUN_LAST);

endmodule

// File: rtl/u8clip_core.sv
module u8clip_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [u8clip_pkg::BYTE_W-1:0]  text_byte,
	input  logic                          start_of_text,
	input  logic [u8clip_pkg::LIMIT_W-1:0] max_lines,
	input  logic [u8clip_pkg::LIMIT_W-1:0] max_columns,
	output u8clip_pkg::clip_dec_t         dec
);
	import u8clip_pkg::*;

	logic [LINE_W-1:0]   line_count_q;
	logic [COLUMN_W-1:0] column_count_q;
	logic                overflowed_q;
	logic                ended_q;

	logic [LINE_W-1:0]   line_cur, line_nxt;
	logic [COLUMN_W-1:0] col_cur, col_nxt;
	logic                ovf_cur, ovf_nxt;
	logic                end_cur, end_nxt;
	logic [LINE_W-1:0]   line_inc;
	logic [COLUMN_W-1:0] col_inc;

	// Start of text clears the state ahead of this byte
	assign line_cur = start_of_text ? '0 : line_count_q;
	assign col_cur  = start_of_text ? '0 : column_count_q;
	assign ovf_cur  = start_of_text ? 1'b0 : overflowed_q;
	assign end_cur  = start_of_text ? 1'b0 : ended_q;

	// Saturating increments
	assign line_inc = (line_cur < LINE_SAT) ? line_cur + 1'b1 : line_cur;
	assign col_inc  = (col_cur < COLUMN_SAT) ? col_cur + 1'b1 : col_cur;

	// Per-byte decision and next state
	always_comb begin
		line_nxt     = line_cur;
		col_nxt      = col_cur;
		ovf_nxt      = ovf_cur;
		end_nxt      = end_cur;
		dec.emit     = 1'b0;
		dec.ellipsis = 1'b0;
		dec.data     = text_byte;
		if (end_cur || text_byte == CH_CR) begin
			// nothing passes
		end else if (text_byte == CH_LF) begin
			line_nxt = line_inc;
			if (line_inc >= max_lines) begin
				end_nxt = 1'b1;
			end else begin
				col_nxt  = '0;
				ovf_nxt  = 1'b0;
				dec.emit = 1'b1;
			end
		end else if (!ovf_cur) begin
			dec.emit = 1'b1;
			if ((text_byte & CONT_MASK) != CONT_MARK) begin
				col_nxt = col_inc;
				if (col_inc > {1'b0, max_columns}) begin
					ovf_nxt      = 1'b1;
					dec.ellipsis = 1'b1;
				end
			end
		end
	end

	// Text state, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q   <= '0;
			column_count_q <= '0;
			overflowed_q   <= 1'b0;
			ended_q        <= 1'b0;
		end else if (fire) begin
			line_count_q   <= line_nxt;
			column_count_q <= col_nxt;
			overflowed_q   <= ovf_nxt;
			ended_q        <= end_nxt;
		end
	end

endmodule

// File: tb/utf8_text_line_column_clipper_tb.sv
`timescale 1ns / 100ps

module utf8_text_line_column_clipper_tb;

	import u8clip_pkg::*;

	// One expected output byte
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} clip_out_t;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// Predicts the clipped text and checks each output byte against it
	class clipped_text_board;
		logic [LIMIT_W-1:0]  max_lines;
		logic [LIMIT_W-1:0]  max_columns;
		logic [LINE_W-1:0]   line_count;
		logic [COLUMN_W-1:0] column_count;
		bit                  line_overflowed;
		bit                  text_ended;
		clip_out_t           clipped_bytes[$];
		int                  mismatches;
		int                  results_checked;
		int                  ellipsis_runs;
		int                  text_ends;

		function new();
			max_lines   = MAX_LINES_RST;
			max_columns = MAX_COLUMNS_RST;
			clear_text();
		endfunction

		function void clear_text();
			line_count      = '0;
			column_count    = '0;
			line_overflowed = 1'b0;
			text_ended      = 1'b0;
		endfunction

		function void set_limit(cfg_idx_t idx, logic [LIMIT_W-1:0] value);
			if (idx == CFG_MAX_LINES)
				max_lines = value;
			else
				max_columns = value;
		endfunction

		function void queue_byte(logic [BYTE_W-1:0] data, logic last);
			clip_out_t item;
			item.data = data;
			item.last = last;
			clipped_bytes = {clipped_bytes, item};
		endfunction

		// Note an accepted byte; returns 1 unless the byte is simply dropped
		function bit note_byte(logic [BYTE_W-1:0] b, logic sot);
			if (sot)
				clear_text();
			if (text_ended || b == CH_CR)
				return 1'b0;
			// line feed: count, then either end the text or pass it on
			if (b == CH_LF) begin
				if (line_count != LINE_SAT)
					line_count++;
				if (line_count >= max_lines) begin
					text_ended = 1'b1;
					text_ends++;
					return 1'b1;
				end
				column_count    = '0;
				line_overflowed = 1'b0;
				queue_byte(CH_LF, 1'b1);
				return 1'b1;
			end
			if (line_overflowed)
				return 1'b0;
			// only lead and single bytes take a column
			if ((b & CONT_MASK) != CONT_MARK) begin
				if (column_count != COLUMN_SAT)
					column_count++;
				if (column_count > {1'b0, max_columns}) begin
					queue_byte(CH_SPACE, 1'b0);
					queue_byte(CH_DOT, 1'b0);
					queue_byte(CH_DOT, 1'b0);
					queue_byte(CH_DOT, 1'b1);
					line_overflowed = 1'b1;
					ellipsis_runs++;
					return 1'b1;
				end
			end
			queue_byte(b, 1'b1);
			return 1'b1;
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 100)
				$display("%0t MISMATCH: %0s", $time, msg);
			mismatches++;
		endtask

		task check_out_byte(logic [BYTE_W-1:0] b, logic last);
			clip_out_t want;
			if (clipped_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b", b, last));
				return;
			end
			want = clipped_bytes.pop_front();
			results_checked++;
			if (b !== want.data)
				report_mismatch($sformatf("out_byte %02h, want %02h", b, want.data));
			if (last !== want.last)
				report_mismatch($sformatf("last_of_run %0b, want %0b", last, want.last));
		endtask
	endclass

	localparam int N_PHASES    = 9;
	localparam int PHASE_ITEMS = 30;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMIT_W-1:0]   cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    text_byte = '0;
	logic                 start_of_text = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BYTE_W-1:0]    out_byte;
	logic                 last_of_run;

	clipped_text_board board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int bytes_accepted = 0;
	int live_bytes = 0;
	int settings_used = 1;

	// Limit settings for the random phases; the extremes and the zero limits among them
	int         phase_lines [N_PHASES] = '{3, 0, 1, 65535, 2, 5, 65535, 4, 200};
	int         phase_cols  [N_PHASES] = '{4, 0, 1, 65535, 0, 3, 2, 65535, 2000};
	idle_mode_t phase_mode  [N_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
		IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_SEND};

	utf8_text_line_column_clipper i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.start_of_text (start_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Input transfers feed the prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			bytes_accepted++;
			if (board.note_byte(text_byte, start_of_text))
				live_bytes++;
		end
	end

	// Output transfers are checked in order
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_out_byte(out_byte, last_of_run);
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_SEND: begin
				send_idle_pct  = 53;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 53;
			end
			IDLE_BOTH: begin
				send_idle_pct  = 36;
				recv_stall_pct = 36;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// Both limits, one per cycle; only called with the block idle
	task automatic write_limits(input logic [LIMIT_W-1:0] lines, input logic [LIMIT_W-1:0] cols);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_LINES;
		cfg_wdata <= lines;
		@(posedge clk);
		cfg_index <= CFG_MAX_COLUMNS;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_limit(CFG_MAX_LINES, lines);
		board.set_limit(CFG_MAX_COLUMNS, cols);
	endtask

	// One input transfer, with random idle cycles ahead of it
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic sot);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		text_byte     <= b;
		start_of_text <= sot;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Lead byte followed by its continuation bytes
	task automatic push_char(input logic [BYTE_W-1:0] lead, input int n_cont, input logic sot);
		push_byte(lead, sot);
		repeat (n_cont)
			push_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
	endtask

	// A line of mixed UTF-8 characters with stray CR and continuation bytes, ended by LF or CR LF
	task automatic send_line(input int cols_hint);
		logic sot;
		int   n_chars;
		int   kind;
		sot     = ($urandom_range(3) == 0);
		n_chars = $urandom_range(0, cols_hint + 2);
		for (int i = 0; i < n_chars; i++) begin
			kind = $urandom_range(99);
			if (kind < 55)
				push_char(8'($urandom_range(8'h20, 8'h7E)), 0, sot);
			else if (kind < 75)
				push_char(8'($urandom_range(8'hC2, 8'hDF)), 1, sot);
			else if (kind < 87)
				push_char(8'($urandom_range(8'hE0, 8'hEF)), 2, sot);
			else if (kind < 93)
				push_char(8'($urandom_range(8'hF0, 8'hF7)), 3, sot);
			else if (kind < 97)
				push_byte(CH_CR, sot);
			else
				push_byte(8'($urandom_range(8'h80, 8'hBF)), sot);
			sot = 1'b0;
		end
		if ($urandom_range(9) == 0) begin
			push_byte(CH_CR, sot);
			sot = 1'b0;
		end
		push_byte(CH_LF, sot);
	endtask

	// Hold the sender off until every expected byte has come out
	task automatic drain_outputs();
		int guard;
		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (board.clipped_bytes.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (board.clipped_bytes.size() != 0) begin
			board.report_mismatch($sformatf("%0d expected bytes never came out",
				board.clipped_bytes.size()));
			board.clipped_bytes.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// Main sequence
	initial begin
		int target;
		int cols_hint;
		board = new();
		set_idle(IDLE_NONE);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset limits: byte extremes, a stray continuation, a dropped CR
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(CH_LF, 1'b0);
		drain_outputs();

		// zero columns: continuations pass, first character becomes the ellipsis,
		// rest of the line is dropped; third LF ends the text, start reopens it
		write_limits(16'd3, 16'd0);
		settings_used++;
		push_byte(8'h80, 1'b0);
		push_byte(8'h78, 1'b0);
		push_byte(8'h79, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(8'hC3, 1'b0);
		push_byte(8'hA9, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(8'h7A, 1'b0);
		push_byte(8'h71, 1'b1);
		drain_outputs();

		// zero lines, set mid-text: any LF ends the text, even on a fresh start
		write_limits(16'd0, 16'd0);
		settings_used++;
		push_byte(CH_LF, 1'b0);
		push_byte(8'h61, 1'b0);
		push_byte(CH_LF, 1'b1);
		push_byte(8'h62, 1'b1);
		drain_outputs();

		// random lines under each setting
		for (int p = 0; p < N_PHASES; p++) begin
			set_idle(phase_mode[p]);
			write_limits(LIMIT_W'(phase_lines[p]), LIMIT_W'(phase_cols[p]));
			settings_used++;
			cols_hint = (phase_cols[p] > 6) ? 6 : phase_cols[p];
			target    = bytes_accepted + PHASE_ITEMS;
			while (bytes_accepted < target) begin
				if ($urandom_range(99) < 85)
					send_line(cols_hint);
				else
					push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
			end
			drain_outputs();
		end

		$display("Covered %0d input bytes (%0d not dropped) over %0d limit settings,",
			bytes_accepted, live_bytes, settings_used);
		$display("%0d output bytes checked, %0d ellipsis runs, %0d texts ended by the line limit.",
			board.results_checked, board.ellipsis_runs, board.text_ends);
		if (board.mismatches == 0)
			$display("utf8_text_line_column_clipper_tb: done, clean");
		else
			$display("utf8_text_line_column_clipper_tb: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("Timeout: run did not finish");
		$display("utf8_text_line_column_clipper_tb: done, errors");
		$finish;
	end

endmodule
